/* src/tvk_pkg.sv */
// ----------------------------------------------------------------------------
// tvk_pkg: shared types and constants of the tensor vote kernel
// Holds the field widths, the divider geometry, the pipeline stage numbers
// and the sideband word that travels alongside each item.
// ----------------------------------------------------------------------------
package tvk_pkg;

  localparam int unsigned FLD_W  = 32;
  localparam int unsigned DATA_W = 9 * FLD_W;
  localparam int unsigned RS_W   = 25;
  localparam logic [RS_W-1:0] RS_RESET = 25'd65536;

  // Restoring dividers: dividend, divisor and quotient widths.
  localparam int unsigned DVD_W = 64;
  localparam int unsigned DSR_W = 35;
  localparam int unsigned QUO_W = 30;

  // Stage numbers (register stage index after acceptance).
  localparam int unsigned SIDE_LAST = 39;
  localparam int unsigned PIPE_LAST = 50;

  // Reciprocals for the exact floor division of small values by 6 and 24.
  localparam logic [18:0] RECIP6  = 19'd349526;
  localparam logic [14:0] RECIP24 = 15'd21846;

  localparam logic [31:0] ONE30  = 32'd1073741824;
  localparam logic [31:0] Q16_ONE = 32'd65536;

  typedef logic signed [FLD_W-1:0] fix_t;

  // Sideband carried down the pipe; fields are filled at the stage that knows them.
  typedef struct packed {
    logic            ident;
    logic [5:0][FLD_W-1:0] w;
    logic [2:0]      neg;
    logic            zero;
    logic            far;
  } side_t;

  // Symmetric pair numbering: xx xy xz yy yz zz.
  localparam int PAIR_IDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
  localparam int PAIR_A [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};

endpackage

/* src/tvk_div.sv */
// ----------------------------------------------------------------------------
// tvk_div: pipelined restoring divider
// One quotient bit per stage, QUO_W stages; the caller guarantees that the
// quotient fits in QUO_W bits. The whole pipe holds while en_i is low.
// ----------------------------------------------------------------------------
module tvk_div import tvk_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic [QUO_W-1:0] quotient_o
);

  logic [DVD_W-1:0] rem_q [QUO_W];
  logic [DSR_W-1:0] dsr_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DVD_W-1:0] rem_d [QUO_W];
  logic [QUO_W-1:0] quo_d [QUO_W];
  logic [DVD_W-1:0] rem_in [QUO_W];
  logic [DSR_W-1:0] dsr_in [QUO_W];
  logic [QUO_W-1:0] quo_in [QUO_W];
  logic [DVD_W-1:0] trial [QUO_W];

  always_comb begin
    rem_in[0] = dividend_i;
    dsr_in[0] = divisor_i;
    quo_in[0] = '0;
    for (int i = 1; i < QUO_W; i++) begin
      rem_in[i] = rem_q[i-1];
      dsr_in[i] = dsr_q[i-1];
      quo_in[i] = quo_q[i-1];
    end
    for (int i = 0; i < QUO_W; i++) begin
      trial[i] = DVD_W'(dsr_in[i]) << (QUO_W - 1 - i);
      if (rem_in[i] >= trial[i]) begin
        rem_d[i] = rem_in[i] - trial[i];
        quo_d[i] = quo_in[i] | (QUO_W'(1) << (QUO_W - 1 - i));
      end else begin
        rem_d[i] = rem_in[i];
        quo_d[i] = quo_in[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QUO_W; i++) begin
        rem_q[i] <= rem_d[i];
        dsr_q[i] <= dsr_in[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign quotient_o = quo_q[QUO_W-1];

endmodule

/* src/tensor_vote_kernel_top.sv */
// ----------------------------------------------------------------------------
// tensor_vote_kernel_top: 3D tensor vote of one neighbour onto one point
//
// Input words arrive on s_axis: tdata carries the offset d and the six
// distinct elements of the symmetric neighbour tensor K, tuser selects the
// identity in place of K. Each word yields one output word on m_axis: the
// row-major 3x3 vote c*R*K*Rp in Q16.16, saturated to 32 bits.
// The single register radius_scale is written through cfg_we_i/cfg_wdata_i;
// write it only while no word is in flight.
// Throughput: one word per cycle while the output buffer has room. A word
// accepted on s_axis goes into the output buffer once it has passed every
// pipe stage and is shown on m_axis_tvalid from then on. The depth is set by
// the 30-stage restoring dividers (one for the weight exponent argument, six
// for the projector), then the weight-side exp polynomial and eight squarings.
// Reset empties the pipe and the output buffer and sets radius_scale to 1.0.
// A two-word output buffer parts the sides: while one result waits, new
// words are still taken; once both entries are full s_axis_tready drops and
// the whole pipe holds, losing and repeating nothing.
// ----------------------------------------------------------------------------
module tensor_vote_kernel_top import tvk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RS_W-1:0]   cfg_wdata_i,    // radius_scale, unsigned Q9.16
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // offset_x, offset_y, offset_z, weight_xx, weight_xy, weight_xz,
  // weight_yy, weight_yz, weight_zz; 32 bits each from bit 0 up
  input  logic [DATA_W-1:0] s_axis_tdata,
  input  logic              s_axis_tuser,   // use_identity
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // vote_xx, vote_xy, vote_xz, vote_yx, vote_yy, vote_yz, vote_zx, vote_zy,
  // vote_zz; 32 bits each from bit 0 up
  output logic [DATA_W-1:0] m_axis_tdata
);

  localparam logic signed [71:0] ONE29_S = 72'sd536870912;
  localparam logic signed [71:0] M_LIM   = 72'sd4294967296;
  localparam logic signed [71:0] I32_MAX = 72'sd2147483647;
  localparam logic signed [71:0] I32_MIN = -72'sd2147483648;

  // Round to nearest, halves away from zero.
  function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v,
                                                 input int unsigned n);
    logic signed [71:0] half;
    half = 72'sd1 <<< (n - 1);
    if (v >= 0) begin
      return (v + half) >>> n;
    end else begin
      return -((-v + half) >>> n);
    end
  endfunction

  // Configuration and flow control.
  logic [RS_W-1:0]      rs_q;
  logic [RS_W-1:0]      rs_eff;
  logic                 en;
  logic [PIPE_LAST:1]   vld_q;

  // Front end: magnitudes, squared distance, normalization.
  fix_t                 off1_q [3];
  side_t                side_q [1:SIDE_LAST];
  side_t                side2_d, side3_d, side5_d;
  logic [31:0]          mag2_q [3];
  logic [63:0]          sq3_q [3];
  logic [31:0]          mx3_q, mx4_q;
  logic [31:0]          nm3_q [3];
  logic [31:0]          nm4_q [3];
  logic [31:0]          nm5_q [3];
  logic [63:0]          s4_q;
  logic [63:0]          dvdw5_q;
  logic [63:0]          pr6_q [6];
  logic [63:0]          pr7_q [6];
  logic [63:0]          ss6;
  logic [DSR_W-1:0]     den7_q;
  logic [31:0]          mx2;
  logic [31:0]          mxa_d;
  logic [31:0]          nma_d [3];
  logic [31:0]          mxb;
  logic [31:0]          nmb_d [3];
  logic [63:0]          thr;
  logic                 far_d;

  // Weight path.
  logic [QUO_W-1:0]     u_div;
  logic [25:0]          ucar_q [36:39];
  logic [21:0]          u2_q [36:39];
  logic [17:0]          u3_q;
  logic [13:0]          u4_q;
  logic [15:0]          q3_q [38:39];
  logic [9:0]           q4_q;
  logic [30:0]          ysq_q [40:48];
  logic [16:0]          c49_q;
  logic [51:0]          m_uu;
  logic [47:0]          m_u3;
  logic [43:0]          m_u4;
  logic [36:0]          m_q3;
  logic [28:0]          m_q4;
  logic [31:0]          y_sum;
  logic [30:0]          y_d;
  logic [61:0]          m_y [8];
  logic [31:0]          c_sum;

  // Projector and matrix path.
  logic [QUO_W-1:0]     pq37 [6];
  fix_t                 p_d [6];
  fix_t                 p38_q [6];
  fix_t                 r_d [3][3];
  fix_t                 rp_d [3][3];
  fix_t                 r39_q [3][3];
  fix_t                 rp_q [39:42][3][3];
  fix_t                 kmat [3][3];
  logic signed [63:0]   prk40_q [3][3][3];
  logic signed [65:0]   acc41_q [3][3];
  logic signed [33:0]   m_d [3][3];
  logic signed [33:0]   m42_q [3][3];
  logic signed [65:0]   pm43_q [3][3][3];
  logic signed [67:0]   acc44_q [3][3];
  logic signed [35:0]   n_d [3][3];
  logic signed [35:0]   n_q [45:49][3][3];
  logic signed [53:0]   fp50_q [3][3];
  logic signed [71:0]   t_m [3][3];
  logic signed [71:0]   t_n [3][3];
  logic signed [71:0]   t_o [3][3];
  logic [DATA_W-1:0]    out_word;

  // Output buffer.
  logic [DATA_W-1:0]    fifo_q [2];
  logic                 wptr_q, rptr_q;
  logic [1:0]           cnt_q;
  logic                 push, pop;

  // Hold the whole pipe only when both buffer entries are taken.
  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;
  assign rs_eff        = (rs_q == '0) ? RS_W'(1) : rs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= RS_RESET;
    end else if (cfg_we_i) begin
      rs_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAST-1:1], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Front-end combinational steps
  // --------------------------------------------------------------------------
  always_comb begin
    mx2 = mag2_q[0];
    if (mag2_q[1] > mx2) begin
      mx2 = mag2_q[1];
    end
    if (mag2_q[2] > mx2) begin
      mx2 = mag2_q[2];
    end
  end

  // Normalize: coarse shifts by 16 and 8.
  always_comb begin
    mxa_d = mx3_q;
    for (int a = 0; a < 3; a++) begin
      nma_d[a] = nm3_q[a];
    end
    if (mxa_d < (32'd1 << 15)) begin
      mxa_d = mxa_d << 16;
      for (int a = 0; a < 3; a++) begin
        nma_d[a] = nma_d[a] << 16;
      end
    end
    if (mxa_d < (32'd1 << 23)) begin
      mxa_d = mxa_d << 8;
      for (int a = 0; a < 3; a++) begin
        nma_d[a] = nma_d[a] << 8;
      end
    end
  end

  // Normalize: fine shifts by 4, 2 and 1, until the largest reaches 2^30.
  always_comb begin
    mxb = mx4_q;
    for (int a = 0; a < 3; a++) begin
      nmb_d[a] = nm4_q[a];
    end
    if (mxb < (32'd1 << 27)) begin
      mxb = mxb << 4;
      for (int a = 0; a < 3; a++) begin
        nmb_d[a] = nmb_d[a] << 4;
      end
    end
    if (mxb < (32'd1 << 29)) begin
      mxb = mxb << 2;
      for (int a = 0; a < 3; a++) begin
        nmb_d[a] = nmb_d[a] << 2;
      end
    end
    if (mxb < (32'd1 << 30)) begin
      for (int a = 0; a < 3; a++) begin
        nmb_d[a] = nmb_d[a] << 1;
      end
    end
  end

  // Far cutoff: weight is zero once s reaches 12 * radius_scale * 2^16.
  assign thr   = (64'(rs_eff) << 19) + (64'(rs_eff) << 18);
  assign far_d = (s4_q >= thr);
  assign ss6   = pr6_q[0] + pr6_q[3] + pr6_q[5];

  // Sideband entering stages 2, 3 and 5 picks up the flags known there.
  always_comb begin
    side2_d = side_q[1];
    for (int a = 0; a < 3; a++) begin
      side2_d.neg[a] = off1_q[a][31];
    end
    side3_d      = side_q[2];
    side3_d.zero = (mx2 == '0);
    side5_d      = side_q[4];
    side5_d.far  = far_d;
  end

  // --------------------------------------------------------------------------
  // Front-end registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: capture the word.
      for (int a = 0; a < 3; a++) begin
        off1_q[a] <= s_axis_tdata[FLD_W*a +: FLD_W];
      end
      side_q[1].ident <= s_axis_tuser;
      for (int k = 0; k < 6; k++) begin
        side_q[1].w[k] <= s_axis_tdata[FLD_W*(3+k) +: FLD_W];
      end
      side_q[1].neg  <= '0;
      side_q[1].zero <= 1'b0;
      side_q[1].far  <= 1'b0;
      // Advance the sideband; stages 2, 3 and 5 fill their own fields.
      side_q[2] <= side2_d;
      side_q[3] <= side3_d;
      side_q[4] <= side_q[3];
      side_q[5] <= side5_d;
      for (int t = 6; t <= SIDE_LAST; t++) begin
        side_q[t] <= side_q[t-1];
      end
      // Stage 2: magnitudes.
      for (int a = 0; a < 3; a++) begin
        mag2_q[a] <= off1_q[a][31] ? 32'(-off1_q[a]) : 32'(off1_q[a]);
      end
      // Stage 3: squares and the largest magnitude.
      for (int a = 0; a < 3; a++) begin
        sq3_q[a] <= 64'(mag2_q[a]) * 64'(mag2_q[a]);
        nm3_q[a] <= mag2_q[a];
      end
      mx3_q <= mx2;
      // Stage 4: squared distance, coarse normalization.
      s4_q  <= sq3_q[0] + sq3_q[1] + sq3_q[2];
      mx4_q <= mxa_d;
      for (int a = 0; a < 3; a++) begin
        nm4_q[a] <= nma_d[a];
      end
      // Stage 5: weight dividend, fine normalization.
      dvdw5_q <= s4_q << 6;
      for (int a = 0; a < 3; a++) begin
        nm5_q[a] <= nmb_d[a];
      end
      // Stage 6: pair products of the normalized magnitudes.
      for (int i = 0; i < 6; i++) begin
        pr6_q[i] <= 64'(nm5_q[PAIR_A[i]]) * 64'(nm5_q[PAIR_B[i]]);
      end
      // Stage 7: projector denominator.
      pr7_q  <= pr6_q;
      den7_q <= ss6[63:29];
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: weight argument u and the six distinct projector entries
  // --------------------------------------------------------------------------
  tvk_div u_div_w (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dvdw5_q),
    .divisor_i  (DSR_W'(rs_eff)),
    .quotient_o (u_div)
  );

  for (genvar gi = 0; gi < 6; gi++) begin : g_pdiv
    tvk_div u_div_p (
      .clk_i      (clk_i),
      .en_i       (en),
      .dividend_i (pr7_q[gi]),
      .divisor_i  (den7_q),
      .quotient_o (pq37[gi])
    );
  end

  // --------------------------------------------------------------------------
  // Weight path: exp(-x) = (1 - u + u^2/2 - u^3/6 + u^4/24)^256
  // --------------------------------------------------------------------------
  assign m_uu  = 52'(u_div[25:0]) * 52'(u_div[25:0]);
  assign m_u3  = 48'(u2_q[36]) * 48'(ucar_q[36]);
  assign m_u4  = 44'(u3_q) * 44'(ucar_q[37]);
  assign m_q3  = 37'(u3_q) * 37'(RECIP6);
  assign m_q4  = 29'(u4_q) * 29'(RECIP24);
  assign y_sum = ONE30 - 32'(ucar_q[39]) + 32'(u2_q[39] >> 1) - 32'(q3_q[39])
               + 32'(q4_q);
  assign y_d   = side_q[SIDE_LAST].far ? '0 : y_sum[30:0];
  assign c_sum = 32'(ysq_q[48]) + 32'd8192;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      m_y[k] = 62'(ysq_q[40+k]) * 62'(ysq_q[40+k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ucar_q[36] <= u_div[25:0];
      u2_q[36]   <= m_uu[51:30];
      for (int t = 37; t <= 39; t++) begin
        ucar_q[t] <= ucar_q[t-1];
        u2_q[t]   <= u2_q[t-1];
      end
      u3_q     <= m_u3[47:30];
      u4_q     <= m_u4[43:30];
      q3_q[38] <= m_q3[36:21];
      q3_q[39] <= q3_q[38];
      q4_q     <= m_q4[28:19];
      ysq_q[40] <= y_d;
      for (int k = 0; k < 8; k++) begin
        ysq_q[41+k] <= m_y[k][60:30];
      end
      c49_q <= c_sum[30:14];
    end
  end

  // --------------------------------------------------------------------------
  // Projector, reflections and the two matrix products
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (side_q[37].zero) begin
        p_d[i] = '0;
      end else if (side_q[37].neg[PAIR_A[i]] ^ side_q[37].neg[PAIR_B[i]]) begin
        p_d[i] = -fix_t'(32'(pq37[i]));
      end else begin
        p_d[i] = fix_t'(32'(pq37[i]));
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        r_d[a][b]  = fix_t'(((a == b) ? ONE29_S : 72'sd0)
                          - 72'sd2 * 72'(p38_q[PAIR_IDX[a][b]]));
        rp_d[a][b] = fix_t'(((a == b) ? ONE29_S : 72'sd0)
                          - rnd_shr(72'sd3 * 72'(p38_q[PAIR_IDX[a][b]]), 1));
        if (side_q[SIDE_LAST].ident) begin
          kmat[a][b] = (a == b) ? fix_t'(Q16_ONE) : '0;
        end else begin
          kmat[a][b] = fix_t'(side_q[SIDE_LAST].w[PAIR_IDX[a][b]]);
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        t_m[a][b] = rnd_shr(72'(acc41_q[a][b]), 29);
        if (t_m[a][b] > M_LIM) begin
          m_d[a][b] = 34'(M_LIM);
        end else if (t_m[a][b] < -M_LIM) begin
          m_d[a][b] = 34'(-M_LIM);
        end else begin
          m_d[a][b] = 34'(t_m[a][b]);
        end
        t_n[a][b] = rnd_shr(72'(acc44_q[a][b]), 29);
        n_d[a][b] = 36'(t_n[a][b]);
        t_o[a][b] = rnd_shr(72'(fp50_q[a][b]), 16);
        if (t_o[a][b] > I32_MAX) begin
          out_word[FLD_W*(3*a+b) +: FLD_W] = 32'(I32_MAX);
        end else if (t_o[a][b] < I32_MIN) begin
          out_word[FLD_W*(3*a+b) +: FLD_W] = 32'(I32_MIN);
        end else begin
          out_word[FLD_W*(3*a+b) +: FLD_W] = 32'(t_o[a][b]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p38_q     <= p_d;
      r39_q     <= r_d;
      rp_q[39]  <= rp_d;
      for (int t = 40; t <= 42; t++) begin
        rp_q[t] <= rp_q[t-1];
      end
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int k = 0; k < 3; k++) begin
            prk40_q[a][b][k] <= r39_q[a][k] * kmat[k][b];
            pm43_q[a][b][k]  <= m42_q[a][k] * rp_q[42][k][b];
          end
          acc41_q[a][b] <= 66'(prk40_q[a][b][0]) + 66'(prk40_q[a][b][1])
                         + 66'(prk40_q[a][b][2]);
          acc44_q[a][b] <= 68'(pm43_q[a][b][0]) + 68'(pm43_q[a][b][1])
                         + 68'(pm43_q[a][b][2]);
          fp50_q[a][b]  <= n_q[49][a][b] * $signed({1'b0, c49_q});
        end
      end
      m42_q   <= m_d;
      n_q[45] <= n_d;
      // Hold N until the weight catches up.
      for (int t = 46; t <= 49; t++) begin
        n_q[t] <= n_q[t-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Two-word output buffer
  // --------------------------------------------------------------------------
  assign push          = en & vld_q[PIPE_LAST];
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = fifo_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= out_word;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipe moved during a stall");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !vld_q[PIPE_LAST]) |=> !m_axis_tvalid)
    else $error("result shown without a finished word");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tensor_vote_kernel_top
// Feeds offset/tensor words through the input stream and compares each output
// word field by field against a typed-in vote or a bit-exact predictor.
// Several radius_scale settings are used, the input and output sides idle at
// random, and once the output side holds off long enough to back the pipe up.
// ----------------------------------------------------------------------------
module testbench;
  import tvk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    fix_t [5:0] w;      // xx xy xz yy yz zz
    logic       ident;
    fix_t [2:0] off;    // x y z
  } pair_t;

  typedef struct {
    pair_t             pair;
    logic              typed;  // expected vote typed in below
    logic [DATA_W-1:0] vote;
  } row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam fix_t ONE  = 32'sd65536;
  localparam fix_t FMAX = 32'sh7fffffff;
  localparam fix_t FMIN = 32'sh80000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [RS_W-1:0]   cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;

  logic [RS_W-1:0]   scale_now = RS_RESET;
  logic [DATA_W-1:0] votes_due[$];
  int                errors = 0;
  int                idle_cycles = 0;
  bit                quiet = 1'b0;     // last phase: no idling on either side
  bit                hold_req = 1'b0;  // ask the sink for one long hold-off
  bit                holding = 1'b0;

  tensor_vote_kernel_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  // Round to nearest, halves away from zero.
  function automatic longint round_shift(longint v, int n);
    u64_t half;
    half = u64_t'(1) << (n - 1);
    if (v >= 0) return longint'((u64_t'(v) + half) >> n);
    return -longint'((u64_t'(-v) + half) >> n);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Distance weight exp(-s/scale) in Q16, via a Q30 Taylor term and 8 squarings.
  function automatic longint distance_weight(u64_t s, logic [RS_W-1:0] scale);
    u64_t r, u, u2, u3, u4, y;
    r = (scale == 0) ? 1 : u64_t'(scale);
    if (s >= 12 * (r << 16)) return 0;
    u  = (s << 6) / r;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    y  = u64_t'(ONE30) + u2 / 2 + u4 / 24 - u - u3 / 6;
    for (int k = 0; k < 8; k++) y = (y * y) >> 30;
    return longint'((y + 8192) >> 14);
  endfunction

  function automatic logic [DATA_W-1:0] predict_vote(pair_t p, logic [RS_W-1:0] scale);
    u64_t   mag[3], nm[3];
    u64_t   s, ss, den, mx, q;
    logic   neg[3];
    longint proj[3][3], rf[3][3], rp[3][3], kt[3][3], m[3][3], n, acc, c;
    logic [DATA_W-1:0] v;
    s = 0; ss = 0; mx = 0;
    for (int a = 0; a < 3; a++) begin
      neg[a] = p.off[a][31];
      mag[a] = neg[a] ? u64_t'(-longint'(p.off[a])) : u64_t'(longint'(p.off[a]));
      s += mag[a] * mag[a];
      if (mag[a] > mx) mx = mag[a];
    end
    c = distance_weight(s, scale);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) proj[a][b] = 0;
    if (mx != 0) begin
      for (int a = 0; a < 3; a++) nm[a] = mag[a];
      // normalize so the largest magnitude lands in [2^30, 2^31]
      while (mx < (u64_t'(1) << 30)) begin
        mx <<= 1;
        for (int a = 0; a < 3; a++) nm[a] <<= 1;
      end
      for (int a = 0; a < 3; a++) ss += nm[a] * nm[a];
      den = ss >> 29;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) begin
          q = (nm[a] * nm[b]) / den;
          proj[a][b] = (neg[a] != neg[b]) ? -longint'(q) : longint'(q);
        end
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        if (p.ident) kt[a][b] = (a == b) ? 65536 : 0;
        else kt[a][b] = longint'(p.w[PAIR_IDX[a][b]]);
        rf[a][b] = ((a == b) ? (longint'(1) << 29) : 0) - 2 * proj[a][b];
        rp[a][b] = ((a == b) ? (longint'(1) << 29) : 0) - round_shift(3 * proj[a][b], 1);
      end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rf[a][k] * kt[k][b];
        m[a][b] = clip(round_shift(acc, 29), -(longint'(1) << 32), longint'(1) << 32);
      end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += m[a][k] * rp[k][b];
        n = round_shift(acc, 29);
        v[(a*3+b)*FLD_W +: FLD_W] = 32'(clip(round_shift(n * c, 16),
                                             -(longint'(1) << 31),
                                             (longint'(1) << 31) - 1));
      end
    return v;
  endfunction

  function automatic pair_t make_pair(fix_t ox, fix_t oy, fix_t oz, logic id,
                                      fix_t xx, fix_t xy, fix_t xz,
                                      fix_t yy, fix_t yz, fix_t zz);
    pair_t p;
    p.off = {oz, oy, ox};
    p.ident = id;
    p.w = {zz, yz, yy, xz, xy, xx};
    return p;
  endfunction

  // Full vote matrix from the symmetric tensor, row-major.
  function automatic logic [DATA_W-1:0] full_matrix(pair_t p);
    logic [DATA_W-1:0] v;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        v[(a*3+b)*FLD_W +: FLD_W] = p.ident ? ((a == b) ? ONE : 32'sd0)
                                            : p.w[PAIR_IDX[a][b]];
    return v;
  endfunction

  // Offset with random magnitude: shift a random word right by 0..31.
  function automatic fix_t rand_offset();
    return fix_t'($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    for (int a = 0; a < 3; a++) p.off[a] = rand_offset();
    p.ident = 1'($urandom_range(0, 1));
    for (int k = 0; k < 6; k++)
      p.w[k] = ($urandom_range(0, 3) == 0) ? fix_t'($urandom)
                                           : fix_t'($urandom) >>> $urandom_range(8, 31);
    return p;
  endfunction

  // Offer one word, hold it until taken, and log the expected vote.
  task automatic send_pair(pair_t p, logic typed, logic [DATA_W-1:0] vote);
    if (!quiet && !holding && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.w, p.off};
    s_axis_tuser  <= p.ident;
    do @(posedge clk_i); while (!s_axis_tready);
    votes_due = {votes_due, (typed ? vote : predict_vote(p, scale_now))};
  endtask

  // Drop valid, let the pipe drain, then write radius_scale.
  task automatic set_scale(logic [RS_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (votes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    scale_now = value;
  endtask

  // Output side: random ready bursts, one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holding = 1'b0;
      end else if (quiet || $urandom_range(0, 1)) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Compare each taken vote with the oldest one due.
  always @(posedge clk_i) begin
    logic [DATA_W-1:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (votes_due.size() == 0) begin
        $display("%0t: unexpected vote %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = votes_due.pop_front();
        for (int f = 0; f < 9; f++)
          if (want[f*FLD_W +: FLD_W] !== m_axis_tdata[f*FLD_W +: FLD_W]) begin
            $display("%0t: vote field %0d expected %h actual %h", $time, f,
                     want[f*FLD_W +: FLD_W], m_axis_tdata[f*FLD_W +: FLD_W]);
            errors++;
          end
      end
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    logic [RS_W-1:0] scales[5];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset scale 1.0. Zero offset returns K as is; a far
    // offset kills the weight.
    r.typed = 1'b1;
    r.pair = make_pair(0, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
    r.vote = full_matrix(r.pair); rows = {rows, r};
    r.pair = make_pair(0, 0, 0, 1'b0, FMAX, FMIN, FMAX, FMIN, FMAX, FMIN);
    r.vote = full_matrix(r.pair); rows = {rows, r};
    r.pair = make_pair(0, 0, 0, 1'b0, FMIN, FMAX, FMIN, FMAX, FMIN, FMAX);
    r.vote = full_matrix(r.pair); rows = {rows, r};
    r.pair = make_pair(0, 0, 0, 1'b0, ONE, -1, 3, -ONE, 7, 12345);
    r.vote = full_matrix(r.pair); rows = {rows, r};
    r.pair = make_pair(FMAX, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
    r.vote = '0; rows = {rows, r};
    r.pair = make_pair(FMIN, FMIN, FMIN, 1'b0, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX);
    r.vote = '0; rows = {rows, r};
    r.pair = make_pair(0, -(ONE * 4), 0, 1'b0, FMAX, 0, 0, FMAX, 0, FMAX);
    r.vote = '0; rows = {rows, r};
    // The rest go through the predictor.
    r.typed = 1'b0;
    r.pair = make_pair(ONE, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0); rows = {rows, r};
    r.pair = make_pair(0, -ONE, 0, 1'b1, 0, 0, 0, 0, 0, 0); rows = {rows, r};
    r.pair = make_pair(ONE, ONE, -ONE, 1'b0, ONE, 0, 0, ONE, 0, ONE); rows = {rows, r};
    r.pair = make_pair(1, 0, 0, 1'b0, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX); rows = {rows, r};
    r.pair = make_pair(-1, 1, -1, 1'b0, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN); rows = {rows, r};
    r.pair = make_pair(ONE/2, -ONE/3, ONE/5, 1'b0, FMAX, FMIN, 0, FMAX, FMIN, FMAX);
    rows = {rows, r};
    r.pair = make_pair(120000, 30000, -7000, 1'b0, -ONE, 2*ONE, -3*ONE, ONE, 0, -ONE);
    rows = {rows, r};
    r.pair = make_pair(226000, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0); rows = {rows, r};
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].vote);

    // Random phases over several scales, from the smallest, 1, up to 16777216.
    scales = '{25'd1, 25'd16777216, 25'd1048576, 25'($urandom_range(1, 16777216)),
               RS_RESET};
    for (int ph = 0; ph < 5; ph++) begin
      set_scale(scales[ph]);
      if (ph == 4) quiet = 1'b1;
      for (int i = 0; i < 340; i++) begin
        if (ph == 1 && i == 100) hold_req = 1'b1;
        send_pair(rand_pair(), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (votes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* sim.f */
src/tvk_pkg.sv
src/tvk_div.sv
src/tensor_vote_kernel_top.sv
tb/sv/testbench.sv
